// ===== rtl/dsu_pkg.sv =====
// Package with shared types, operation codes and constants for the divide/shift unit.
package dsu_pkg;

  localparam int DW = 64;
  localparam int EW = 2;
  localparam int OW = 3;
  localparam logic [DW-1:0] SHIFT_LIMIT = DW'(1024);

  localparam logic [OW-1:0] OP_SMOD  = 3'd0;
  localparam logic [OW-1:0] OP_UMOD  = 3'd1;
  localparam logic [OW-1:0] OP_SFDIV = 3'd2;
  localparam logic [OW-1:0] OP_SLSH  = 3'd3;
  localparam logic [OW-1:0] OP_ULSH  = 3'd4;
  localparam logic [OW-1:0] OP_SRSH  = 3'd5;
  localparam logic [OW-1:0] OP_URSH  = 3'd6;

  localparam logic [EW-1:0] ERR_OK      = 2'd0;
  localparam logic [EW-1:0] ERR_DIVZERO = 2'd1;
  localparam logic [EW-1:0] ERR_NEGSH   = 2'd2;
  localparam logic [EW-1:0] ERR_BIGSH   = 2'd3;

  // One request in flight through the divider chain.
  typedef struct packed {
    logic          valid;
    logic [OW-1:0] op;
    logic          an;
    logic          bn;
    logic [DW-1:0] b;
    logic          fixed;
    logic [DW-1:0] fix_res;
    logic [EW-1:0] fix_err;
    logic [DW-1:0] bm;
    logic [DW-1:0] rem;
    logic [DW-1:0] dq;
  } item_t;

endpackage

// ===== rtl/dsu_front.sv =====
// Front end: operand magnitudes, special cases and the complete shift operations.
module dsu_front import dsu_pkg::*; (
  input  logic          valid,
  input  logic [OW-1:0] req_type,
  input  logic [DW-1:0] operand_a,
  input  logic [DW-1:0] operand_b,
  output item_t         item
);

  logic          an, bn, a_zero, b_neg, b_small, b_big;
  logic [DW-1:0] am, bm, sar;
  logic [5:0]    sh;

  always_comb begin
    an      = operand_a[DW-1];
    bn      = operand_b[DW-1];
    am      = an ? (DW'(0) - operand_a) : operand_a;
    bm      = bn ? (DW'(0) - operand_b) : operand_b;
    a_zero  = (operand_a == '0);
    b_neg   = operand_b[DW-1];
    b_small = (operand_b[DW-1:6] == '0);
    b_big   = !a_zero && (operand_b >= SHIFT_LIMIT);
    sh      = operand_b[5:0];
    sar     = an ? ~((~operand_a) >> sh) : (operand_a >> sh);

    item.valid   = valid;
    item.op      = req_type;
    item.an      = an;
    item.bn      = bn;
    item.b       = operand_b;
    item.fixed   = 1'b1;
    item.fix_res = '0;
    item.fix_err = ERR_OK;
    item.bm      = bm;
    item.rem     = '0;
    item.dq      = am;

    case (req_type)
      OP_SMOD: begin
        item.fixed = (operand_b == '0) || (operand_b == DW'(1)) ||
                     (operand_b == '1) || a_zero;
      end
      OP_UMOD: begin
        item.bm    = operand_b;
        item.dq    = operand_a;
        item.fixed = (operand_b == '0);
      end
      OP_SFDIV: begin
        if (operand_b == '0) begin
          item.fix_err = ERR_DIVZERO;
        end else if (operand_a == {1'b1, {(DW-1){1'b0}}} && operand_b == '1) begin
          item.fix_res = DW'(1);
        end else begin
          item.fixed = 1'b0;
        end
      end
      OP_SLSH: begin
        if (b_neg) item.fix_err = ERR_NEGSH;
        else if (b_big) item.fix_err = ERR_BIGSH;
        else if (b_small) item.fix_res = operand_a << sh;
      end
      OP_ULSH: begin
        if (b_neg || b_big) item.fix_err = ERR_BIGSH;
        else if (b_small) item.fix_res = operand_a << sh;
      end
      OP_SRSH: begin
        if (b_neg) item.fix_err = ERR_NEGSH;
        else if (b_small) item.fix_res = sar;
        else item.fix_res = an ? '1 : '0;
      end
      OP_URSH: begin
        if (b_neg) item.fix_err = ERR_BIGSH;
        else if (b_small) item.fix_res = operand_a >> sh;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dsu_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands the item on.
module dsu_cell import dsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t din,
  output item_t dout
);

  logic [DW:0]   trial;
  logic          fits;
  item_t         step;

  always_comb begin
    trial     = {din.rem, din.dq[DW-1]};
    fits      = (trial >= {1'b0, din.bm});
    step      = din;
    step.rem  = fits ? DW'(trial - {1'b0, din.bm}) : trial[DW-1:0];
    step.dq   = {din.dq[DW-2:0], fits};
  end

  // Reset only clears the valid bit; the payload simply follows when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= step;
    end
  end

endmodule

// ===== rtl/dsu_back.sv =====
// Back end: applies floored sign rules to quotient and remainder.
module dsu_back import dsu_pkg::*; (
  input  item_t         item,
  output logic [DW-1:0] res,
  output logic [EW-1:0] err
);

  logic [DW-1:0] q, m;

  always_comb begin
    q   = item.dq;
    m   = item.rem;
    res = '0;
    err = ERR_OK;
    if (item.fixed) begin
      err = item.fix_err;
      res = (item.fix_err == ERR_OK) ? item.fix_res : '0;
    end else begin
      case (item.op)
        OP_SMOD: begin
          if (m == '0) res = '0;
          else if (item.an == item.bn) res = item.bn ? (DW'(0) - m) : m;
          else res = item.bn ? (item.b + m) : (item.b - m);
        end
        OP_UMOD: res = m;
        OP_SFDIV: begin
          if (item.an == item.bn) res = q;
          else res = (DW'(0) - q) - DW'(m != '0);
        end
        default: res = '0;
      endcase
    end
  end

endmodule

// ===== rtl/python_int_div_mod_shift_unit.sv =====
// Top level of the floored divide, modulo and shift unit.
//
//   channel | signals                                   | direction
//   request | in_valid, in_stall, req_type, operand_a/b  | in
//   result  | out_valid, out_stall, result_word, error_code | out
//
// Every request passes through the 64 division cells of the chain and then
// the output register. The chain takes a new request every cycle unless the
// result is stalled, so the sustained rate is one per cycle; shifts and
// special cases ride along the chain to keep order.
// Reset (rst, synchronous) clears the valid bits of all cells and the output.
// A stalled result freezes the whole chain, and in_stall follows it.
module python_int_div_mod_shift_unit import dsu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [OW-1:0] req_type,
  input  logic [DW-1:0] operand_a,
  input  logic [DW-1:0] operand_b,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [DW-1:0] result_word,
  output logic [EW-1:0] error_code
);

  // The chain moves whenever the output register can be refilled.
  logic          advance;
  item_t         chain [DW+1];
  logic [DW-1:0] res;
  logic [EW-1:0] err;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  dsu_front u_front (
    .valid     (in_valid),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .item      (chain[0])
  );

  // Each cell resolves one quotient bit, most significant first.
  for (genvar i = 0; i < DW; i++) begin : g_cell
    dsu_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  dsu_back u_back (
    .item (chain[DW]),
    .res  (res),
    .err  (err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[DW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= res;
      error_code  <= err;
    end
  end

endmodule

// ===== rtl/dsu_checker.sv =====
// Port-level checker for the divide/shift unit, bound to the top level.
module dsu_checker import dsu_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [DW-1:0] result_word,
  input logic [EW-1:0] error_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_word) && $stable(error_code))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |-> result_word == '0)
    else $error("error result carries nonzero word");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a blocked result");

endmodule

bind python_int_div_mod_shift_unit dsu_checker u_dsu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_word (result_word),
  .error_code  (error_code)
);
